@@ sv/igmf_pkg.sv @@
`timescale 1ns / 1ps

package igmf_pkg;

   // Ring and slot geometry.
   localparam int SLOT_COUNT    = 16;
   localparam int MESSAGE_BYTES = 64;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int POS_W         = $clog2(MESSAGE_BYTES);
   // The byte index must be able to hold MESSAGE_BYTES itself.
   localparam int IDX_W         = POS_W + 1;

   // Gap threshold register.
   localparam int               GAP_W     = 16;
   localparam logic [GAP_W-1:0] GAP_RESET = 16'd100;

   // Request commands.
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  rx_byte;
      logic [15:0] idle_ticks;
      logic [15:0] left_count;
      logic [15:0] right_count;
      logic [63:0] time_now;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   byte_pos;
      logic [7:0]         byte_out;
      logic               byte_valid;
      logic               new_message;
      logic               header_valid;
      logic signed [15:0] left_delta;
      logic signed [15:0] right_delta;
      logic [63:0]        stamp;
      logic [15:0]        overflow_count;
   } rsp_type;

endpackage

@@ sv/igmf_core.sv @@
`timescale 1ns / 1ps

module igmf_core
   import igmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data,
   input  logic             req_fire,
   input  req_type          req_data,
   output rsp_type          result
);

   logic [GAP_W-1:0]  gap_ff;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] oldest_slot_ff, oldest_slot_in;
   logic [IDX_W-1:0]  byte_index_ff, byte_index_in;
   logic [15:0]       lost_count_ff, lost_count_in;
   logic [15:0]       last_left_ff, last_left_in;
   logic [15:0]       last_right_ff, last_right_in;
   logic [IDX_W-1:0]  idx_base;
   logic [IDX_W-1:0]  idx_clamp;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(SLOT_COUNT - 1)) begin
         return '0;
      end
      return s + 1'b1;
   endfunction

   // Next state and result for the request on the input.
   always_comb begin
      write_slot_in  = write_slot_ff;
      oldest_slot_in = oldest_slot_ff;
      byte_index_in  = byte_index_ff;
      lost_count_in  = lost_count_ff;
      last_left_in   = last_left_ff;
      last_right_in  = last_right_ff;
      idx_base       = byte_index_ff;
      idx_clamp      = byte_index_ff;
      result         = '0;
      if (req_data.command == CMD_RELEASE) begin
         // An empty ring ignores the release.
         if (oldest_slot_ff != write_slot_ff) begin
            oldest_slot_in = next_slot(oldest_slot_ff);
         end
         result.slot = oldest_slot_in;
      end else begin
         if (req_data.idle_ticks >= gap_ff) begin
            if (next_slot(write_slot_ff) != oldest_slot_ff) begin
               idx_base           = '0;
               write_slot_in      = next_slot(write_slot_ff);
               result.new_message = 1'b1;
               result.stamp       = req_data.time_now;
            end else begin
               lost_count_in = lost_count_ff + 16'd1;
            end
            result.header_valid = 1'b1;
            result.left_delta   = req_data.left_count - last_left_ff;
            result.right_delta  = req_data.right_count - last_right_ff;
            last_left_in        = req_data.left_count;
            last_right_in       = req_data.right_count;
         end
         // Long messages keep overwriting the last byte of the slot.
         if (idx_base >= IDX_W'(MESSAGE_BYTES)) begin
            idx_clamp = IDX_W'(MESSAGE_BYTES - 1);
         end else begin
            idx_clamp = idx_base;
         end
         byte_index_in     = idx_clamp + 1'b1;
         result.byte_pos   = idx_clamp[POS_W-1:0];
         result.byte_out   = req_data.rx_byte;
         result.byte_valid = 1'b1;
         result.slot       = write_slot_in;
      end
      result.overflow_count = lost_count_in;
   end

   // Framer state, updated once for each accepted request; the gap threshold on a register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff         <= GAP_RESET;
         write_slot_ff  <= '0;
         oldest_slot_ff <= '0;
         byte_index_ff  <= '0;
         lost_count_ff  <= '0;
         last_left_ff   <= '0;
         last_right_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
         if (req_fire) begin
            write_slot_ff  <= write_slot_in;
            oldest_slot_ff <= oldest_slot_in;
            byte_index_ff  <= byte_index_in;
            lost_count_ff  <= lost_count_in;
            last_left_ff   <= last_left_in;
            last_right_ff  <= last_right_in;
         end
      end
   end

`ifndef SYNTHESIS
   // A newly opened slot always starts at position zero and carries a header.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && result.new_message) |-> (result.byte_pos == '0 && result.header_valid))
      else $error("new message not at position zero or without header");

   // A release of a non-empty ring moves the oldest slot on.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_RELEASE && oldest_slot_ff != write_slot_ff)
      |=> (oldest_slot_ff != $past(oldest_slot_ff)))
      else $error("release did not free the oldest slot");

   // The byte index never runs past the end of a slot.
   assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= IDX_W'(MESSAGE_BYTES))
      else $error("byte index beyond slot length");

   // Opening a slot never makes the write slot catch up with the oldest one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && result.new_message) |=> (write_slot_ff != oldest_slot_ff))
      else $error("ring overrun on new message");
`endif

endmodule

@@ sv/igmf_rsp_reg.sv @@
`timescale 1ns / 1ps

module igmf_rsp_reg
   import igmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    req_fire,
   input  rsp_type result,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // A new request is taken whenever the held result is gone or leaves now.
   assign req_ready = !valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         data_ff <= result;
      end
   end

endmodule

@@ sv/idle_gap_message_framer.sv @@
`timescale 1ns / 1ps
// Results are registered: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the single result register lets a new
// request in while the held result is taken in the same cycle.
// Reset is synchronous and active high: the ring is emptied, all counters and
// encoder baselines go to zero and the gap threshold returns to 100.

module idle_gap_message_framer
   import igmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data
);

   logic    req_fire;
   rsp_type result;

   // Framing logic and state.
   igmf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .result      (result)
   );

   // Output register and handshake.
   igmf_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_fire  (req_fire),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/framer_checker.sv @@
`timescale 1ns / 1ps

module framer_checker
   import igmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               records_waiting
);

   // Shadow copy of the framer state and its gap threshold.
   logic [GAP_W-1:0]  gap_limit;
   logic [SLOT_W-1:0] fill_slot;
   logic [SLOT_W-1:0] drain_slot;
   logic [IDX_W-1:0]  fill_index;
   logic [15:0]       lost_messages;
   logic [15:0]       base_left;
   logic [15:0]       base_right;

   // Store records still owed by the block, oldest first.
   rsp_type expected_records[$];
   rsp_type predicted;
   rsp_type wanted;

   function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
      int n;
      n = (int'(s) + 1) % SLOT_COUNT;
      return n[SLOT_W-1:0];
   endfunction

   // Works out the store record for one request and advances the shadow state.
   task frame_request(input req_type r, output rsp_type e);
      e = '0;
      if (r.command == CMD_RELEASE) begin
         // Releasing an empty ring leaves the oldest slot where it is.
         if (drain_slot != fill_slot) begin
            drain_slot = slot_after(drain_slot);
         end
         e.slot = drain_slot;
      end else begin
         if (r.idle_ticks >= gap_limit) begin
            // A long gap opens a slot, or counts a lost message when full.
            if (slot_after(fill_slot) != drain_slot) begin
               fill_index    = '0;
               fill_slot     = slot_after(fill_slot);
               e.new_message = 1'b1;
               e.stamp       = r.time_now;
            end else begin
               lost_messages = lost_messages + 16'd1;
            end
            e.header_valid = 1'b1;
            e.left_delta   = r.left_count - base_left;
            e.right_delta  = r.right_count - base_right;
            base_left      = r.left_count;
            base_right     = r.right_count;
         end
         // Bytes beyond the slot size keep landing on its last position.
         if (fill_index >= IDX_W'(MESSAGE_BYTES)) begin
            fill_index = IDX_W'(MESSAGE_BYTES - 1);
         end
         e.byte_pos   = fill_index[POS_W-1:0];
         fill_index   = fill_index + 1'b1;
         e.byte_valid = 1'b1;
         e.byte_out   = r.rx_byte;
         e.slot       = fill_slot;
      end
      e.overflow_count = lost_messages;
   endtask

   task check_field(input string field_name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field_name, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // Results are matched before new requests are predicted, since a result
   // never belongs to a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         gap_limit     = GAP_RESET;
         fill_slot     = '0;
         drain_slot    = '0;
         fill_index    = '0;
         lost_messages = '0;
         base_left     = '0;
         base_right    = '0;
         expected_records.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               $error("Store record arrived with no request outstanding");
               mismatch_count = mismatch_count + 1;
            end else begin
               wanted = expected_records.pop_front();
               check_field("slot", wanted.slot, rsp_data.slot);
               check_field("byte_pos", wanted.byte_pos, rsp_data.byte_pos);
               check_field("byte_out", wanted.byte_out, rsp_data.byte_out);
               check_field("byte_valid", wanted.byte_valid, rsp_data.byte_valid);
               check_field("new_message", wanted.new_message, rsp_data.new_message);
               check_field("header_valid", wanted.header_valid, rsp_data.header_valid);
               check_field("left_delta", wanted.left_delta, rsp_data.left_delta);
               check_field("right_delta", wanted.right_delta, rsp_data.right_delta);
               check_field("stamp", wanted.stamp, rsp_data.stamp);
               check_field("overflow_count", wanted.overflow_count,
                           rsp_data.overflow_count);
            end
         end
         if (req_valid && req_ready) begin
            frame_request(req_data, predicted);
            expected_records.push_back(predicted);
         end
         if (csr_wr_en) begin
            gap_limit = csr_wr_data;
         end
      end
      records_waiting = expected_records.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import igmf_pkg::*;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS      = 300;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [GAP_W-1:0] csr_wr_data;

   int          mismatch_count;
   int          records_waiting;
   int          gap_setting;
   logic [15:0] left_now;
   logic [15:0] right_now;
   logic [63:0] clock_stamp;
   bit          calm_stretch;
   bit          hold_rsp_request;
   int          quiet_cycles;

   idle_gap_message_framer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   framer_checker framing_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .records_waiting (records_waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is abandoned when no request and no result moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Encoders drift slowly with the odd jump; the timestamp mostly creeps up.
   task automatic advance_sensors();
      if ($urandom_range(0, 15) == 0) begin
         left_now  = 16'($urandom);
         right_now = 16'($urandom);
      end else begin
         left_now  = left_now + 16'($urandom_range(0, 64)) - 16'd32;
         right_now = right_now + 16'($urandom_range(0, 64)) - 16'd32;
      end
      if ($urandom_range(0, 31) == 0) begin
         clock_stamp = {$urandom, $urandom};
      end else begin
         clock_stamp = clock_stamp + 64'($urandom_range(1, 5000));
      end
   endtask

   // Offers one request after a random gap and waits until it is taken.
   task automatic offer_request(input logic cmd, input logic [7:0] rx, input logic [15:0] idle);
      req_type item;
      int      gap;
      item.command     = cmd;
      item.rx_byte     = rx;
      item.idle_ticks  = idle;
      item.left_count  = left_now;
      item.right_count = right_now;
      item.time_now    = clock_stamp;
      gap = calm_stretch ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] gap_idle();
      if ($urandom_range(0, 3) == 0) return 16'(gap_setting);
      return 16'($urandom_range(gap_setting, 65535));
   endfunction

   function automatic logic [15:0] run_idle();
      if ($urandom_range(0, 3) == 0) return 16'(gap_setting - 1);
      return 16'($urandom_range(0, gap_setting - 1));
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      while (records_waiting != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_gap(input logic [15:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gap_setting = int'(value);
      @(negedge clock);
   endtask

   // Mostly whole messages (a gap byte, then bytes inside the gap), mixed with
   // releases and the odd request of random content.
   task automatic run_phase(input int release_pct, input int calm_items, input bit squeeze);
      int sent;
      int pick;
      int msg_len;
      int k;
      sent         = 0;
      calm_stretch = (calm_items > 0);
      if (squeeze) begin
         hold_rsp_request = 1'b1;
      end
      while (sent < PHASE_ITEMS) begin
         if (sent >= calm_items) begin
            calm_stretch = 1'b0;
         end
         pick = $urandom_range(0, 99);
         advance_sensors();
         if (pick < release_pct) begin
            offer_request(CMD_RELEASE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            sent = sent + 1;
         end else if (pick < 92) begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 6);
            offer_request(CMD_BYTE, 8'($urandom_range(0, 255)), gap_idle());
            for (k = 1; k < msg_len; k++) begin
               advance_sensors();
               offer_request(CMD_BYTE, 8'($urandom_range(0, 255)), run_idle());
            end
            sent = sent + msg_len;
         end else begin
            offer_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            sent = sent + 1;
         end
      end
      calm_stretch = 1'b0;
   endtask

   // Result side: a random stall before each result, a long hold when asked.
   initial begin : result_taker
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = calm_stretch ? 0 : $urandom_range(0, 4);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int k;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      calm_stretch     = 1'b0;
      hold_rsp_request = 1'b0;
      gap_setting      = int'(GAP_RESET);
      left_now         = '0;
      right_now        = '0;
      clock_stamp      = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset threshold. A release on the empty
      // ring comes first, then bytes either side of the threshold.
      offer_request(CMD_RELEASE, 8'h00, 16'h0000);
      offer_request(CMD_BYTE, 8'h00, 16'd0);
      offer_request(CMD_BYTE, 8'hFF, GAP_RESET - 16'd1);
      left_now    = 16'hFFFF;
      right_now   = 16'h0001;
      clock_stamp = '1;
      offer_request(CMD_BYTE, 8'hA5, GAP_RESET);
      left_now    = 16'h0000;
      right_now   = 16'h8000;
      clock_stamp = '0;
      offer_request(CMD_BYTE, 8'h5A, 16'hFFFF);
      // Two releases empty the ring; the third finds it empty.
      repeat (3) offer_request(CMD_RELEASE, 8'hFF, 16'hFFFF);
      offer_request(CMD_BYTE, 8'h3C, 16'd1);
      // Open slots until the ring is full, then lose one message.
      for (k = 0; k < 16; k++) begin
         left_now    = left_now + 16'h4000;
         right_now   = right_now - 16'h1234;
         clock_stamp = clock_stamp + 64'h1_0000_0001;
         offer_request(CMD_BYTE, k[7:0], 16'hFFFF);
      end
      drain_results();

      // Random phases over a spread of thresholds, the extremes among them.
      run_phase(40, 0, 1'b0);
      write_gap(16'd1);
      run_phase(10, 60, 1'b0);
      write_gap(16'hFFFF);
      run_phase(40, 80, 1'b1);
      write_gap(16'($urandom_range(2, 200)));
      run_phase(70, 0, 1'b0);
      write_gap(16'($urandom_range(201, 65534)));
      run_phase(25, 150, 1'b0);
      write_gap(GAP_RESET);
      run_phase(40, 0, 1'b0);

      drain_results();
      repeat (5) @(negedge clock);
      if (mismatch_count == 0 && records_waiting == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
